// ===== rtl/sbl_pkg.sv =====
// ----------------------------------------------------------------------------
// Sobel edge magnitude package
// Shared widths, register indexes and types for the 3x3 Sobel edge block.
// ----------------------------------------------------------------------------
package sbl_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int PIX_W        = 8;
    localparam int SUM_W        = PIX_W + 2;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int ROW_W        = $clog2(HEIGHT_LIMIT);
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_IDX_W    = 1;

    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = WIDTH_REG_W'(640);
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = HEIGHT_REG_W'(480);
    localparam logic [PIX_W-1:0]        SAT_MAX      = PIX_W'(255);

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    // Position flags of one pixel, carried alongside it through the pipeline.
    typedef struct packed {
        logic emit;
        logic last;
    } t_flags;

endpackage

// ===== rtl/sbl_raster.sv =====
// ----------------------------------------------------------------------------
// Raster position tracker
// Holds the frame size registers and the column and row counters, and flags
// each pixel that completes an interior window and the last pixel of a frame.
// ----------------------------------------------------------------------------
module sbl_raster (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [sbl_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sbl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          i_advance,
    output logic [sbl_pkg::COL_W-1:0]     o_col,
    output sbl_pkg::t_flags               o_flags
);
    import sbl_pkg::*;

    logic [WIDTH_REG_W-1:0]  r_width;
    logic [HEIGHT_REG_W-1:0] r_height;
    logic [COL_W-1:0]        r_col, n_col;
    logic [ROW_W-1:0]        r_row, n_row;
    logic [WIDTH_REG_W-1:0]  w_eff;
    logic [HEIGHT_REG_W-1:0] h_eff;
    logic [COL_W-1:0]        col_last;
    logic [ROW_W-1:0]        row_last;
    logic                    at_col_end;
    logic                    at_row_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_IMAGE_WIDTH:  r_width  <= i_cfg_data[WIDTH_REG_W-1:0];
                REG_IMAGE_HEIGHT: r_height <= i_cfg_data[HEIGHT_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // Out-of-range sizes are clamped into the supported range.
    always_comb begin
        w_eff = r_width;
        if (r_width < WIDTH_REG_W'(3))
            w_eff = WIDTH_REG_W'(3);
        else if (r_width > WIDTH_REG_W'(MAX_WIDTH))
            w_eff = WIDTH_REG_W'(MAX_WIDTH);
        h_eff = r_height;
        if (r_height < HEIGHT_REG_W'(3))
            h_eff = HEIGHT_REG_W'(3);
        else if (r_height > HEIGHT_REG_W'(HEIGHT_LIMIT))
            h_eff = HEIGHT_REG_W'(HEIGHT_LIMIT);
    end

    assign col_last   = COL_W'(w_eff - WIDTH_REG_W'(1));
    assign row_last   = ROW_W'(h_eff - HEIGHT_REG_W'(1));
    assign at_col_end = (r_col >= col_last);
    assign at_row_end = (r_row >= row_last);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_advance) begin
            if (at_col_end) begin
                n_col = '0;
                n_row = at_row_end ? '0 : r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign o_col        = r_col;
    assign o_flags.emit = (r_row >= ROW_W'(2)) && (r_col >= COL_W'(2));
    assign o_flags.last = at_row_end && at_col_end;

endmodule

// ===== rtl/sbl_line_buf.sv =====
// ----------------------------------------------------------------------------
// Line stores
// Two row memories holding the previous two rows. Each entry is read when a
// pixel is accepted and rewritten one stage later when that pixel moves on.
// ----------------------------------------------------------------------------
module sbl_line_buf (
    input  logic                      i_clk,
    input  logic                      i_rd_en,
    input  logic [sbl_pkg::COL_W-1:0] i_rd_addr,
    input  logic                      i_wr_en,
    input  logic [sbl_pkg::COL_W-1:0] i_wr_addr,
    input  logic [sbl_pkg::PIX_W-1:0] i_wr_px,
    output logic [sbl_pkg::PIX_W-1:0] o_up,
    output logic [sbl_pkg::PIX_W-1:0] o_mid
);
    import sbl_pkg::*;

    logic [PIX_W-1:0] mem_upper  [MAX_WIDTH];
    logic [PIX_W-1:0] mem_middle [MAX_WIDTH];
    logic [PIX_W-1:0] r_up;
    logic [PIX_W-1:0] r_mid;

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_up  <= mem_upper[i_rd_addr];
            r_mid <= mem_middle[i_rd_addr];
        end
    end

    // The middle row entry moves up and the new pixel takes its place.
    // Successive pixels never share a column, so a read never meets a
    // pending write to the same entry.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem_upper[i_wr_addr]  <= r_mid;
            mem_middle[i_wr_addr] <= i_wr_px;
        end
    end

    assign o_up  = r_up;
    assign o_mid = r_mid;

endmodule

// ===== rtl/sbl_kernel.sv =====
// ----------------------------------------------------------------------------
// Sobel kernel
// Shifts the 3x3 window, forms |gx| + |gy| with saturation and holds the
// result word in the output register.
// ----------------------------------------------------------------------------
module sbl_kernel (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_load,
    input  logic [sbl_pkg::PIX_W-1:0] i_up,
    input  logic [sbl_pkg::PIX_W-1:0] i_mid,
    input  logic [sbl_pkg::PIX_W-1:0] i_px,
    input  sbl_pkg::t_flags           i_flags,
    input  logic                      i_out_ready,
    output logic                      o_out_valid,
    output logic [sbl_pkg::PIX_W-1:0] o_edge,
    output logic                      o_last
);
    import sbl_pkg::*;

    // r_left holds the window's left column once shifted, r_centre the middle.
    logic [PIX_W-1:0]   r_left   [3];
    logic [PIX_W-1:0]   r_centre [3];
    logic [PIX_W-1:0]   p00, p01, p02, p10, p12, p20, p21, p22;
    logic [SUM_W-1:0]   s_right, s_left, s_top, s_bottom;
    logic signed [SUM_W:0] gx, gy;
    logic [SUM_W-1:0]   ax, ay;
    logic [SUM_W:0]     mag;
    logic [PIX_W-1:0]   n_edge;
    logic               r_valid;
    logic [PIX_W-1:0]   r_edge;
    logic               r_last;

    assign p00 = r_left[0];
    assign p10 = r_left[1];
    assign p20 = r_left[2];
    assign p01 = r_centre[0];
    assign p21 = r_centre[2];
    assign p02 = i_up;
    assign p12 = i_mid;
    assign p22 = i_px;

    always_comb begin
        s_right  = SUM_W'(p02) + {1'b0, p12, 1'b0} + SUM_W'(p22);
        s_left   = SUM_W'(p00) + {1'b0, p10, 1'b0} + SUM_W'(p20);
        s_top    = SUM_W'(p00) + {1'b0, p01, 1'b0} + SUM_W'(p02);
        s_bottom = SUM_W'(p20) + {1'b0, p21, 1'b0} + SUM_W'(p22);
        gx = $signed({1'b0, s_right}) - $signed({1'b0, s_left});
        gy = $signed({1'b0, s_top}) - $signed({1'b0, s_bottom});
        ax = gx[SUM_W] ? SUM_W'(-gx) : gx[SUM_W-1:0];
        ay = gy[SUM_W] ? SUM_W'(-gy) : gy[SUM_W-1:0];
        mag = (SUM_W+1)'(ax) + (SUM_W+1)'(ay);
        n_edge = (mag > (SUM_W+1)'(SAT_MAX)) ? SAT_MAX : mag[PIX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_left[i]   <= '0;
                r_centre[i] <= '0;
            end
        end else if (i_load) begin
            for (int i = 0; i < 3; i++) begin
                r_left[i] <= r_centre[i];
            end
            r_centre[0] <= i_up;
            r_centre[1] <= i_mid;
            r_centre[2] <= i_px;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load && i_flags.emit) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_flags.emit) begin
            r_edge <= n_edge;
            r_last <= i_flags.last;
        end
    end

    assign o_out_valid = r_valid;
    assign o_edge      = r_edge;
    assign o_last      = r_last;

endmodule

// ===== rtl/sobel_edge_magnitude_3x3.sv =====
// A pixel and its line-store entries are registered at the accepting edge, and
// its result word enters the output register when the pixel moves on.
// Throughput: one pixel per cycle while the master side takes each word.
// Border pixels give no word; the last interior pixel of a frame sets tlast.
// Reset (synchronous, active low) clears counters, window and valid flags and
// sets the frame size to 640 x 480; line-store contents are kept.
// ----------------------------------------------------------------------------
// Sobel edge magnitude, 3x3
// Streams a grayscale frame in raster order and emits the saturated L1 Sobel
// gradient magnitude for every interior pixel.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_3x3 (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [sbl_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sbl_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,  // [7:0] pixel
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [7:0]                      m_axis_tdata,  // [7:0] edge_value
    output logic                            m_axis_tlast   // frame_last
);
    import sbl_pkg::*;

    logic             accept;
    logic             advance;
    logic [COL_W-1:0] col;
    t_flags           flags;
    logic             r_s1_valid;
    t_flags           r_s1_flags;
    logic [PIX_W-1:0] r_s1_px;
    logic [COL_W-1:0] r_s1_col;
    logic [PIX_W-1:0] up_px;
    logic [PIX_W-1:0] mid_px;
    logic             out_valid;

    // A pixel with no result never waits on the output register.
    assign advance = r_s1_valid && (!r_s1_flags.emit || !out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || advance;
    assign accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_flags <= flags;
            r_s1_px    <= s_axis_tdata;
            r_s1_col   <= col;
        end
    end

    sbl_raster u_raster (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_advance   (accept),
        .o_col       (col),
        .o_flags     (flags)
    );

    sbl_line_buf u_line_buf (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (col),
        .i_wr_en   (advance),
        .i_wr_addr (r_s1_col),
        .i_wr_px   (r_s1_px),
        .o_up      (up_px),
        .o_mid     (mid_px)
    );

    sbl_kernel u_kernel (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (advance),
        .i_up        (up_px),
        .i_mid       (mid_px),
        .i_px        (r_s1_px),
        .i_flags     (r_s1_flags),
        .i_out_ready (m_axis_tready),
        .o_out_valid (out_valid),
        .o_edge      (m_axis_tdata),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tvalid = out_valid;

endmodule

// ===== rtl/sbl_checker.sv =====
// ----------------------------------------------------------------------------
// Sobel edge port checker
// Watches the top-level ports for output hold, reset and flow-control slips.
// ----------------------------------------------------------------------------
module sbl_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_tready,
    input logic       i_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] i_m_tdata,
    input logic       i_m_tlast
);

    // A stalled result word keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata)
                                      && $stable(i_m_tlast))
        else $error("result word changed while stalled");

    // Reset leaves no result word pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("result valid straight after reset");

    // When the master side takes every word, the slave side is never held off.
    a_no_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tready |-> i_s_tready)
        else $error("input stalled although output is ready");

    // An input held off in one cycle means a result word was waiting in it.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_s_tready |-> i_m_tvalid && !i_m_tready)
        else $error("input stalled without a waiting result word");

endmodule

bind sobel_edge_magnitude_3x3 sbl_checker u_sbl_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tlast  (m_axis_tlast)
);

// ===== verif/tb_sobel_edge_magnitude_3x3.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sobel edge magnitude testbench
// Streams grayscale frames through the 3x3 Sobel block and checks every result
// word against a table for the directed 3x3 frames and otherwise against a
// cycle-free model of the line stores, window and counters. The frame size is
// changed between frames and, where the line stores already hold valid pixels, mid-frame.
// ----------------------------------------------------------------------------
module tb_sobel_edge_magnitude_3x3;
    import sbl_pkg::*;

    localparam int RANDOM_PIXELS = 650;
    localparam int SETTLE_CYCLES = 4;
    localparam int QUIET_LIMIT   = 4000;

    typedef struct packed {
        logic [7:0] mag;
        logic       frame_end;
    } t_mag_word;

    typedef enum int {TEX_NOISE, TEX_FLAT, TEX_BINARY, TEX_DIM} t_texture;
    typedef enum int {RX_OPEN, RX_COIN, RX_COMB, RX_SPARSE} t_rx_mode;

    // Three 3x3 frames: a dark-to-bright step, a flat white frame and a lone
    // grey level in the top-left corner. Each has a single interior pixel.
    localparam logic [0:26][7:0] DIR_PIXELS = {
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 8'd255, 8'd255,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
        8'd1,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0
    };
    localparam logic [0:2][7:0] DIR_MAGS = {8'd255, 8'd0, 8'd2};

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [7:0]            m_axis_tdata;
    logic                  m_axis_tlast;

    // Model of the block.
    logic [WIDTH_REG_W-1:0]  cfg_width  = WIDTH_RESET;
    logic [HEIGHT_REG_W-1:0] cfg_height = HEIGHT_RESET;
    logic [7:0]              line_up  [MAX_WIDTH];
    logic [7:0]              line_mid [MAX_WIDTH];
    bit                      line_up_ok  [MAX_WIDTH];
    bit                      line_mid_ok [MAX_WIDTH];
    logic [7:0]              win [3][3];
    int                      col_pos = 0;
    int                      row_pos = 0;

    t_mag_word expected_mags [$];
    int        mismatches   = 0;
    int        pixels_sent  = 0;
    int        burst_left   = 0;
    int        quiet_cycles = 0;
    t_rx_mode  rx_mode      = RX_OPEN;
    int        rx_left      = 0;

    sobel_edge_magnitude_3x3 dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] pixel
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [7:0] edge_value
        .m_axis_tlast  (m_axis_tlast)    // frame_last
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int eff_width(input logic [WIDTH_REG_W-1:0] raw);
        if (raw < 3) return 3;
        if (raw > MAX_WIDTH) return MAX_WIDTH;
        return int'(raw);
    endfunction

    function automatic int eff_height(input logic [HEIGHT_REG_W-1:0] raw);
        if (raw < 3) return 3;
        if (raw > HEIGHT_LIMIT) return HEIGHT_LIMIT;
        return int'(raw);
    endfunction

    // Number of leading columns whose entries in both line stores hold pixels.
    function automatic int stores_span();
        int n;
        n = 0;
        while (n < MAX_WIDTH && line_up_ok[n] && line_mid_ok[n]) n++;
        return n;
    endfunction

    function automatic logic [7:0] random_pixel(input t_texture tex, input logic [7:0] base);
        int v;
        case (tex)
            TEX_NOISE:  v = $urandom_range(0, 255);
            TEX_FLAT: begin
                v = int'(base) + int'($urandom_range(0, 6)) - 3;
                if (v < 0) v = 0;
                if (v > 255) v = 255;
            end
            TEX_BINARY: v = ($urandom_range(0, 1) == 1) ? 255 : 0;
            default:    v = $urandom_range(0, 3);
        endcase
        return v[7:0];
    endfunction

    // Advances the model by one pixel and gives the magnitude word it causes.
    task automatic sobel_step(input logic [7:0] px, output bit produced, output t_mag_word word);
        int w;
        int h;
        int gx;
        int gy;
        int mag;
        logic [7:0] up;
        logic [7:0] md;
        w  = eff_width(cfg_width);
        h  = eff_height(cfg_height);
        up = line_up[col_pos];
        md = line_mid[col_pos];
        line_up[col_pos]     = md;
        line_up_ok[col_pos]  = line_mid_ok[col_pos];
        line_mid[col_pos]    = px;
        line_mid_ok[col_pos] = 1'b1;
        for (int i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = up;
        win[1][2] = md;
        win[2][2] = px;

        produced = (row_pos >= 2 && col_pos >= 2);
        word     = '0;
        if (produced) begin
            gx = (int'(win[0][2]) + 2 * int'(win[1][2]) + int'(win[2][2]))
               - (int'(win[0][0]) + 2 * int'(win[1][0]) + int'(win[2][0]));
            gy = (int'(win[0][0]) + 2 * int'(win[0][1]) + int'(win[0][2]))
               - (int'(win[2][0]) + 2 * int'(win[2][1]) + int'(win[2][2]));
            mag = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
            if (mag > 255) mag = 255;
            word.mag       = mag[7:0];
            word.frame_end = (row_pos >= h - 1 && col_pos >= w - 1);
        end

        if (col_pos >= w - 1) begin
            col_pos = 0;
            row_pos = (row_pos >= h - 1) ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
    endtask

    // Offers one pixel, sometimes idling first when the current burst is used up.
    task automatic push_pixel(input logic [7:0] px, input bit use_typed,
                              input logic [7:0] typed_mag);
        int gap;
        bit produced;
        t_mag_word word;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 48);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        sobel_step(px, produced, word);
        if (produced) begin
            if (use_typed) begin
                word.mag       = typed_mag;
                word.frame_end = 1'b1;
            end
            expected_mags.push_back(word);
        end
        burst_left--;
        pixels_sent++;
    endtask

    // Holds off the stream until every word is out and the pipeline is empty.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_mags.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(input logic [WIDTH_REG_W-1:0] w_raw,
                             input logic [HEIGHT_REG_W-1:0] h_raw);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= REG_IMAGE_WIDTH;
        i_cfg_data  <= CFG_DATA_W'(w_raw);
        @(posedge i_clk);
        cfg_width = w_raw;
        i_cfg_index <= REG_IMAGE_HEIGHT;
        i_cfg_data  <= h_raw;
        @(posedge i_clk);
        cfg_height = h_raw;
        i_cfg_wr_en <= 1'b0;
    endtask

    // Sends pixels until the frame wraps; the size may change at pixel switch_at.
    task automatic run_frame(input t_texture tex, input int switch_at,
                             input logic [WIDTH_REG_W-1:0] sw_w,
                             input logic [HEIGHT_REG_W-1:0] sw_h);
        int n;
        logic [7:0] base;
        n    = 0;
        base = 8'($urandom_range(0, 255));
        do begin
            if (n == switch_at) begin
                settle();
                // A wider row must not reach line-store entries never filled.
                if (eff_width(sw_w) > stores_span()) sw_w = cfg_width;
                configure(sw_w, sw_h);
            end
            push_pixel(random_pixel(tex, base), 1'b0, 8'd0);
            n++;
        end while (col_pos != 0 || row_pos != 0);
    endtask

    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
            rx_left <= $urandom_range(16, 160);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_OPEN: m_axis_tready <= 1'b1;
            RX_COIN: m_axis_tready <= 1'($urandom_range(0, 1));
            RX_COMB: m_axis_tready <= (rx_left % 4 == 0);
            default: m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge i_clk) begin : check_words
        t_mag_word want;
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            if (expected_mags.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected word: expected none, actual mag %0d last %0b",
                         $time, m_axis_tdata, m_axis_tlast);
            end else begin
                want = expected_mags.pop_front();
                if (m_axis_tdata !== want.mag) begin
                    mismatches++;
                    $display("%0t: edge_value mismatch: expected %0d, actual %0d",
                             $time, want.mag, m_axis_tdata);
                end
                if (m_axis_tlast !== want.frame_end) begin
                    mismatches++;
                    $display("%0t: frame_last mismatch: expected %0b, actual %0b",
                             $time, want.frame_end, m_axis_tlast);
                end
            end
        end
    end

    // Watchdog: a long stretch with no word moving on either side is a hang.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready === 1'b1) ||
            (m_axis_tvalid === 1'b1 && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL sobel_edge_magnitude_3x3");
            $finish;
        end
    end

    initial begin
        int random_start;
        int pick;
        int sw_at;
        logic [WIDTH_REG_W-1:0]  w_raw;
        logic [HEIGHT_REG_W-1:0] h_raw;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) win[i][j] = 8'd0;
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Smallest frame size; only the last pixel of each frame gives a word.
        configure(WIDTH_REG_W'(3), HEIGHT_REG_W'(3));
        for (int i = 0; i < 27; i++)
            push_pixel(DIR_PIXELS[i], (i % 9 == 8), DIR_MAGS[i / 9]);

        // Width above the limit clamps to the widest row; once that row is
        // through, the width drops so that the frame ends two short rows later.
        settle();
        configure(WIDTH_REG_W'(2047), HEIGHT_REG_W'(3));
        run_frame(TEX_NOISE, MAX_WIDTH, WIDTH_REG_W'(3), HEIGHT_REG_W'(3));

        // Largest legal width, cut short in the first row.
        settle();
        configure(WIDTH_REG_W'(MAX_WIDTH), HEIGHT_REG_W'(6));
        run_frame(TEX_FLAT, 12, WIDTH_REG_W'(3), HEIGHT_REG_W'(6));

        // Largest legal height, lowered in the third row to end the frame there.
        settle();
        configure(WIDTH_REG_W'(4), HEIGHT_REG_W'(HEIGHT_LIMIT));
        run_frame(TEX_BINARY, 10, WIDTH_REG_W'(4), HEIGHT_REG_W'(3));

        random_start = pixels_sent;
        while (pixels_sent - random_start < RANDOM_PIXELS) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                w_raw = WIDTH_REG_W'($urandom_range(0, 2));
                h_raw = HEIGHT_REG_W'($urandom_range(3, 8));
            end else if (pick == 1) begin
                w_raw = WIDTH_REG_W'($urandom_range(3, 16));
                h_raw = HEIGHT_REG_W'($urandom_range(0, 2));
            end else begin
                w_raw = WIDTH_REG_W'($urandom_range(3, 20));
                h_raw = HEIGHT_REG_W'($urandom_range(3, 10));
            end
            settle();
            configure(w_raw, h_raw);
            repeat ($urandom_range(1, 3)) begin
                sw_at = -1;
                if ($urandom_range(0, 4) == 0)
                    sw_at = $urandom_range(1, eff_width(w_raw) * eff_height(h_raw) - 1);
                run_frame(t_texture'($urandom_range(0, 3)), sw_at,
                          WIDTH_REG_W'($urandom_range(0, 24)),
                          HEIGHT_REG_W'($urandom_range(0, 12)));
            end
        end

        // Height above the limit must not end the frame early; after ten rows
        // the height drops so that the frame ends with the current row.
        settle();
        configure(WIDTH_REG_W'(3), HEIGHT_REG_W'(8191));
        run_frame(TEX_FLAT, 30, WIDTH_REG_W'(3), HEIGHT_REG_W'(3));

        settle();
        if (mismatches == 0) begin
            $display("PASS sobel_edge_magnitude_3x3");
        end else begin
            $display("FAIL sobel_edge_magnitude_3x3");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/sbl_pkg.sv
rtl/sbl_raster.sv
rtl/sbl_line_buf.sv
rtl/sbl_kernel.sv
rtl/sobel_edge_magnitude_3x3.sv
rtl/sbl_checker.sv
verif/tb_sobel_edge_magnitude_3x3.sv
